FILE: rtl/usbcdc_pkg.sv
// ============================================================================
// usbcdc_pkg
// Shared types and constants for the CDC endpoint-zero control handler.
// ============================================================================
package usbcdc_pkg;

    // Default chunk size of one IN packet, in bytes (1 to 8)
    localparam int PACKET_BYTES_DEF = 8;

    // Setup request codes
    localparam logic [7:0] REQ_GET_DESCRIPTOR         = 8'h06;
    localparam logic [7:0] REQ_SET_ADDRESS            = 8'h05;
    localparam logic [7:0] REQ_SET_CONFIGURATION      = 8'h09;
    localparam logic [7:0] REQ_SET_LINE_CODING        = 8'h20;
    localparam logic [7:0] REQ_GET_LINE_CODING        = 8'h21;
    localparam logic [7:0] REQ_SET_CONTROL_LINE_STATE = 8'h22;

    // Descriptor layout inside the ROM
    localparam logic [6:0] DEVICE_BASE  = 7'd0;
    localparam logic [6:0] DEVICE_LEN   = 7'd18;
    localparam logic [6:0] CONFIG_BASE  = 7'd18;
    localparam logic [6:0] CONFIG_TOTAL = 7'd67;
    localparam int         ROM_LEN      = 85;

    // Descriptor types (high byte of the setup value)
    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_CONFIG = 8'd2;

    // Event codes
    typedef enum logic [1:0] {
        ACT_SETUP = 2'd0,
        ACT_IN    = 2'd1,
        ACT_OUT   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Response codes
    typedef enum logic [1:0] {
        RSP_NONE  = 2'd0,
        RSP_SEND  = 2'd1,
        RSP_STALL = 2'd2,
        RSP_ADDR  = 2'd3
    } t_rsp;

    // One control event
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
        logic [55:0] out_payload;
    } t_in;

    // One endpoint answer
    typedef struct packed {
        logic [1:0]  response;
        logic [63:0] packet_bytes;
        logic [3:0]  packet_count;
        logic [6:0]  device_address;
        logic        configured;
    } t_out;

    // Decoded answer handed from the control stage to the ROM stage
    typedef struct packed {
        t_rsp        rsp;
        logic        from_rom;
        logic [6:0]  rom_start;
        logic [3:0]  count;
        logic [63:0] line_bytes;
        logic [6:0]  addr;
        logic        cfg;
    } t_cmd;

endpackage

FILE: rtl/usbcdc_rom.sv
// ============================================================================
// usbcdc_rom
// Descriptor ROM with one wide synchronous read port: eight consecutive
// bytes from a start offset, bytes past the packet count or the ROM end forced to zero.
// ============================================================================
module usbcdc_rom (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [6:0]  i_start,
    input  logic [3:0]  i_count,
    output logic [63:0] o_bytes
);

    // Device descriptor followed by the full configuration set
    localparam logic [7:0] DESC_ROM [0:usbcdc_pkg::ROM_LEN-1] = '{
        // device
        8'd18, 8'd1, 8'h00, 8'h02, 8'h02, 8'd0, 8'd0, 8'd8, 8'h01, 8'h00,
        8'h01, 8'h00, 8'h00, 8'h01, 8'd0, 8'd0, 8'd0, 8'd1,
        // configuration
        8'd9, 8'd2, 8'd67, 8'd0, 8'd2, 8'd1, 8'd0, 8'h80, 8'd1,
        // communication interface
        8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'h02, 8'h02, 8'd0, 8'd0,
        // header functional
        8'd5, 8'h24, 8'h00, 8'h10, 8'h01,
        // call management functional
        8'd5, 8'h24, 8'h01, 8'h00, 8'd1,
        // abstract control functional
        8'd4, 8'h24, 8'h02, 8'h02,
        // union functional
        8'd5, 8'h24, 8'h06, 8'd0, 8'd1,
        // notification endpoint
        8'd7, 8'd5, 8'h81, 8'h03, 8'd8, 8'd0, 8'd10,
        // data interface
        8'd9, 8'd4, 8'd1, 8'd0, 8'd2, 8'h0A, 8'h00, 8'd0, 8'd0,
        // bulk out endpoint
        8'd7, 8'd5, 8'h02, 8'h02, 8'd32, 8'd0, 8'd0,
        // bulk in endpoint
        8'd7, 8'd5, 8'h82, 8'h02, 8'd32, 8'd0, 8'd0
    };

    logic [63:0] n_bytes;
    logic [7:0]  lane_addr [8];

    // Per-lane lookup, zero past the ROM end or past the count
    always_comb begin
        n_bytes = '0;
        for (int i = 0; i < 8; i++) begin
            lane_addr[i] = {1'b0, i_start} + 8'(i);
            if ((lane_addr[i] < 8'(usbcdc_pkg::ROM_LEN)) && (4'(i) < i_count)) begin
                n_bytes[8*i +: 8] = DESC_ROM[lane_addr[i][6:0]];
            end
        end
    end

    // Registered read data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_bytes <= n_bytes;
        end
    end

endmodule

FILE: rtl/usbcdc_ctl.sv
// ============================================================================
// usbcdc_ctl
// Control-transfer sequencer: decodes each event against the endpoint
// context, writes the context back and registers the decoded answer.
// ============================================================================
module usbcdc_ctl #(
    parameter int PACKET_BYTES = usbcdc_pkg::PACKET_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  usbcdc_pkg::t_in    i_in_data,
    output logic               o_in_stall,
    input  logic               i_adv,
    output logic               o_cmd_valid,
    output usbcdc_pkg::t_cmd   o_cmd
);

    localparam logic [6:0] PKT_MAX = 7'(PACKET_BYTES);
    localparam int         LINE_N  = (PACKET_BYTES < 7) ? PACKET_BYTES : 7;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEND = 2'd1,
        PH_ADDR = 2'd2,
        PH_LINE = 2'd3
    } t_phase;

    // Endpoint context
    t_phase      r_phase,   n_phase;
    logic [6:0]  r_pending, n_pending;
    logic [6:0]  r_addr,    n_addr;
    logic [55:0] r_line,    n_line;
    logic        r_cfg,     n_cfg;
    logic [6:0]  r_offset,  n_offset;
    logic [6:0]  r_left,    n_left;

    // Decoded answer stage
    logic              r_cmd_valid;
    usbcdc_pkg::t_cmd  r_cmd, n_cmd;

    logic        accept;
    logic        load;
    logic [6:0]  ch_start, ch_len, ch_n;
    logic        ch_do;
    logic [6:0]  size;
    logic [6:0]  base;
    logic        type_ok;

    assign load        = !r_cmd_valid || i_adv;
    assign o_in_stall  = !load;
    assign accept      = i_in_valid && load;
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;

    // Descriptor selection from the setup value
    always_comb begin
        type_ok = 1'b1;
        base    = usbcdc_pkg::DEVICE_BASE;
        size    = usbcdc_pkg::DEVICE_LEN;
        if (i_in_data.request_value[15:8] == usbcdc_pkg::DESC_DEVICE) begin
            base = usbcdc_pkg::DEVICE_BASE;
            size = usbcdc_pkg::DEVICE_LEN;
        end else if (i_in_data.request_value[15:8] == usbcdc_pkg::DESC_CONFIG) begin
            base = usbcdc_pkg::CONFIG_BASE;
            size = usbcdc_pkg::CONFIG_TOTAL;
        end else begin
            type_ok = 1'b0;
        end
    end

    // Event decode and context update
    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_addr    = r_addr;
        n_line    = r_line;
        n_cfg     = r_cfg;
        n_offset  = r_offset;
        n_left    = r_left;
        n_cmd     = '0;
        n_cmd.rsp = usbcdc_pkg::RSP_NONE;
        ch_do     = 1'b0;
        ch_start  = r_offset;
        ch_len    = r_left;

        unique case (usbcdc_pkg::t_action'(i_in_data.action))
            usbcdc_pkg::ACT_SETUP: begin
                unique case (i_in_data.request_code)
                    usbcdc_pkg::REQ_GET_DESCRIPTOR: begin
                        if (type_ok) begin
                            ch_do    = 1'b1;
                            ch_start = base;
                            ch_len   = (i_in_data.request_length < {9'd0, size}) ?
                                       i_in_data.request_length[6:0] : size;
                        end else begin
                            n_cmd.rsp = usbcdc_pkg::RSP_STALL;
                            n_phase   = PH_IDLE;
                        end
                    end
                    usbcdc_pkg::REQ_SET_ADDRESS: begin
                        n_pending = i_in_data.request_value[6:0];
                        n_left    = '0;
                        n_cmd.rsp = usbcdc_pkg::RSP_SEND;
                        n_phase   = PH_ADDR;
                    end
                    usbcdc_pkg::REQ_SET_CONFIGURATION: begin
                        n_cfg     = 1'b1;
                        n_left    = '0;
                        n_cmd.rsp = usbcdc_pkg::RSP_SEND;
                        n_phase   = PH_IDLE;
                    end
                    usbcdc_pkg::REQ_SET_LINE_CODING: begin
                        n_phase = PH_LINE;
                    end
                    usbcdc_pkg::REQ_GET_LINE_CODING: begin
                        for (int i = 0; i < LINE_N; i++) begin
                            n_cmd.line_bytes[8*i +: 8] = r_line[8*i +: 8];
                        end
                        n_cmd.count = 4'(LINE_N);
                        n_left      = '0;
                        n_cmd.rsp   = usbcdc_pkg::RSP_SEND;
                        n_phase     = PH_IDLE;
                    end
                    usbcdc_pkg::REQ_SET_CONTROL_LINE_STATE: begin
                        n_left    = '0;
                        n_cmd.rsp = usbcdc_pkg::RSP_SEND;
                        n_phase   = PH_IDLE;
                    end
                    default: begin
                        n_cmd.rsp = usbcdc_pkg::RSP_STALL;
                        n_phase   = PH_IDLE;
                    end
                endcase
            end
            usbcdc_pkg::ACT_IN: begin
                if (r_phase == PH_SEND && r_left != '0) begin
                    ch_do = 1'b1;
                end else if (r_phase == PH_ADDR) begin
                    n_addr    = r_pending;
                    n_cmd.rsp = usbcdc_pkg::RSP_ADDR;
                    n_phase   = PH_IDLE;
                end
            end
            usbcdc_pkg::ACT_OUT: begin
                if (r_phase == PH_LINE) begin
                    n_line    = i_in_data.out_payload;
                    n_left    = '0;
                    n_cmd.rsp = usbcdc_pkg::RSP_SEND;
                    n_phase   = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        // Next descriptor chunk
        ch_n = (ch_len < PKT_MAX) ? ch_len : PKT_MAX;
        if (ch_do) begin
            n_cmd.rsp       = usbcdc_pkg::RSP_SEND;
            n_cmd.from_rom  = 1'b1;
            n_cmd.rom_start = ch_start;
            n_cmd.count     = ch_n[3:0];
            n_offset        = ch_start + ch_n;
            n_left          = ch_len - ch_n;
            n_phase         = (ch_len != ch_n) ? PH_SEND : PH_IDLE;
        end

        n_cmd.addr = n_addr;
        n_cmd.cfg  = n_cfg;
    end

    // Context and answer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pending   <= '0;
            r_addr      <= '0;
            r_line      <= '0;
            r_cfg       <= 1'b0;
            r_offset    <= '0;
            r_left      <= '0;
            r_cmd_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_pending <= n_pending;
                r_addr    <= n_addr;
                r_line    <= n_line;
                r_cfg     <= n_cfg;
                r_offset  <= n_offset;
                r_left    <= n_left;
            end
            if (load) begin
                r_cmd_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: rtl/usb_cdc_control_endpoint.sv
// ============================================================================
// usb_cdc_control_endpoint
// Endpoint-zero control handler for a CDC serial device.
//
//   channel   dir   handshake               payload
//   in        in    i_in_valid/o_in_stall   i_in_data  (t_in)
//   out       out   o_out_valid/i_out_stall o_out_data (t_out)
//
// One event per cycle is accepted unless stalled; its answer passes the control/
// context stage, then the output stage with the registered descriptor ROM read.
// Context update is done in the accept cycle, so back-to-back events see it.
// Reset returns the endpoint to idle, address 0, not configured.
// A stalled output holds its transfer and back-pressures through both stages.
// ============================================================================
module usb_cdc_control_endpoint #(
    parameter int PACKET_BYTES = usbcdc_pkg::PACKET_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  usbcdc_pkg::t_in   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output usbcdc_pkg::t_out  o_out_data
);

    logic              cmd_valid;
    usbcdc_pkg::t_cmd  cmd;
    logic              adv;
    logic [63:0]       rom_bytes;

    // Output stage registers
    logic              r_valid;
    usbcdc_pkg::t_rsp  r_rsp;
    logic              r_from_rom;
    logic [63:0]       r_line;
    logic [3:0]        r_count;
    logic [6:0]        r_addr;
    logic              r_cfg;

    assign adv = !r_valid || !i_out_stall;

    usbcdc_ctl #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_adv       (adv),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    usbcdc_rom u_rom (
        .i_clk   (i_clk),
        .i_en    (adv && cmd_valid),
        .i_start (cmd.rom_start),
        .i_count (cmd.count),
        .o_bytes (rom_bytes)
    );

    // Output stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= cmd_valid;
        end
    end

    // Output stage payload
    always_ff @(posedge i_clk) begin
        if (adv && cmd_valid) begin
            r_rsp      <= cmd.rsp;
            r_from_rom <= cmd.from_rom;
            r_line     <= cmd.line_bytes;
            r_count    <= cmd.count;
            r_addr     <= cmd.addr;
            r_cfg      <= cmd.cfg;
        end
    end

    // Result transfer
    assign o_out_valid                = r_valid;
    assign o_out_data.response        = r_rsp;
    assign o_out_data.packet_bytes    = r_from_rom ? rom_bytes : r_line;
    assign o_out_data.packet_count    = r_count;
    assign o_out_data.device_address  = r_addr;
    assign o_out_data.configured      = r_cfg;

endmodule
